// ===== rtl/mjte_pkg.sv =====
// Shared constants for the minimum-jumps block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mjte_pkg;
	localparam int LEN_W            = 16;
	localparam int COST_W           = 20;
	localparam int MAX_ELEMENTS_DEF = 256;

	localparam logic [COST_W-1:0] DEAD_COST = COST_W'(999999);
	localparam logic [COST_W-1:0] COST_ONE  = COST_W'(1);
	localparam logic [COST_W-1:0] COST_ZERO = '0;
endpackage

// ===== rtl/mjte_len_mem.sv =====
// Jump-length store: one write port, one read port, registered read data.
// Depends on mjte_pkg for the element width.
`timescale 1ns / 1ps

module mjte_len_mem
	import mjte_pkg::*;
#(
	parameter int DEPTH = MAX_ELEMENTS_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic signed [LEN_W-1:0] wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output logic signed [LEN_W-1:0] rdata
);
	logic signed [LEN_W-1:0] mem [DEPTH];
	logic signed [LEN_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/mjte_cost_mem.sv =====
// Per-position cost store: one write port, one read port, registered read data.
// Depends on mjte_pkg for the cost width.
`timescale 1ns / 1ps

module mjte_cost_mem
	import mjte_pkg::*;
#(
	parameter int DEPTH = MAX_ELEMENTS_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [COST_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [COST_W-1:0] rdata
);
	logic [COST_W-1:0] mem [DEPTH];
	logic [COST_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/min_jumps_to_array_end_top.sv =====
// Minimum jumps to reach the end of an array: loader, backward sequencer, result register.
// Depends on mjte_pkg, mjte_len_mem and mjte_cost_mem.
//
// Usage: drive start with jump_length and is_last; a request is taken at a rising edge
// where start is high and busy is low. Elements load at one per cycle into the length
// memory; the first MAX_ELEMENTS are kept, later ones are dropped and flag too_long.
// The request with is_last high closes the array and raises busy while the backward
// pass runs over the cost memory, newest position first. Each position reads its length
// and is settled there when it is dead or its jump clears the end; else its reachable
// window is scanned, one cost memory read per cycle, and the least cost plus one is
// written. A one-element array answers on the next cycle. done pulses for exactly one
// cycle with min_jumps, unreachable and too_long; the receiver cannot hold it off, and
// busy is already low in that cycle, so the next array may start there. Reset clears
// the element count, the overflow flag and the sequencer; memory contents stay
// undefined and are always written before they are read.
`timescale 1ns / 1ps

module min_jumps_to_array_end_top
	import mjte_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [LEN_W-1:0] jump_length,
	input  logic                    is_last,
	output logic                    busy,
	output logic                    done,
	output logic [COST_W-1:0]       min_jumps,
	output logic                    unreachable,
	output logic                    too_long
);
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int RW = ((CW > LEN_W) ? CW : LEN_W) + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ELEMENTS - 1);
	localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_ELEMENTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LREQ,
		S_LEN,
		S_SCAN,
		S_DRAIN
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic              ovf_q;
	logic [CW-1:0]     n_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     j_q;
	logic [AW-1:0]     end_q;
	logic              pend_q;
	logic [COST_W-1:0] best_q;
	logic              done_q;
	logic [COST_W-1:0] min_jumps_q;
	logic              unreachable_q;
	logic              too_long_q;

	logic                    accept;
	logic                    room;
	logic [CW-1:0]           n_next;
	logic                    ovf_next;
	logic signed [LEN_W-1:0] len_rd;
	logic [COST_W-1:0]       cost_rd;
	logic                    len_pos;
	logic [RW-1:0]           reach;
	logic [RW-1:0]           last_pos;
	logic [COST_W-1:0]       min_c;
	logic                    cwe;
	logic [AW-1:0]           cwaddr;
	logic [COST_W-1:0]       cwdata;
	logic                    pos_done;

	assign accept   = start && (state_q == S_IDLE);
	assign room     = count_q < MAX_CNT;
	assign n_next   = room ? count_q + CW'(1) : count_q;
	assign ovf_next = ovf_q || !room;

	assign len_pos  = !len_rd[LEN_W-1] && (len_rd != '0);
	assign reach    = RW'(i_q) + RW'(len_rd[LEN_W-2:0]);
	assign last_pos = RW'(n_q) - RW'(1);
	assign min_c    = (cost_rd < best_q) ? cost_rd : best_q;

	// Cost write port: the end position gets zero at close, then one write per position.
	always_comb begin
		cwe      = 1'b0;
		cwaddr   = i_q;
		cwdata   = COST_ZERO;
		pos_done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cwe    = accept && is_last;
				cwaddr = room ? count_q[AW-1:0] : LAST_ADDR;
			end
			S_LEN: begin
				if (!len_pos) begin
					cwe      = 1'b1;
					cwdata   = DEAD_COST;
					pos_done = 1'b1;
				end else if (reach >= last_pos) begin
					cwe      = 1'b1;
					cwdata   = COST_ONE;
					pos_done = 1'b1;
				end
			end
			S_DRAIN: begin
				cwe      = 1'b1;
				cwdata   = min_c + COST_ONE;
				pos_done = 1'b1;
			end
			default: begin
				cwe = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			ovf_q         <= 1'b0;
			n_q           <= '0;
			i_q           <= '0;
			j_q           <= '0;
			end_q         <= '0;
			pend_q        <= 1'b0;
			best_q        <= '1;
			done_q        <= 1'b0;
			min_jumps_q   <= '0;
			unreachable_q <= 1'b0;
			too_long_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			pend_q <= (state_q == S_SCAN);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= n_next;
						ovf_q   <= ovf_next;
						if (is_last) begin
							n_q <= n_next;
							i_q <= AW'(n_next - CW'(2));
							if (n_next == CW'(1)) begin
								// single element: answer at once
								done_q        <= 1'b1;
								min_jumps_q   <= COST_ZERO;
								unreachable_q <= 1'b0;
								too_long_q    <= ovf_next;
								count_q       <= '0;
								ovf_q         <= 1'b0;
							end else begin
								state_q <= S_LREQ;
							end
						end
					end
				end
				S_LREQ: begin
					state_q <= S_LEN;
				end
				S_LEN: begin
					if (!pos_done) begin
						j_q     <= i_q + AW'(1);
						end_q   <= reach[AW-1:0];
						best_q  <= '1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// strict compare keeps the earliest index on ties
					if (pend_q && (cost_rd < best_q)) begin
						best_q <= cost_rd;
					end
					if (j_q == end_q) begin
						state_q <= S_DRAIN;
					end else begin
						j_q <= j_q + AW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_DRAIN;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (pos_done) begin
				if (i_q == '0) begin
					done_q        <= 1'b1;
					min_jumps_q   <= cwdata;
					unreachable_q <= (cwdata >= DEAD_COST);
					too_long_q    <= ovf_q;
					count_q       <= '0;
					ovf_q         <= 1'b0;
					state_q       <= S_IDLE;
				end else begin
					i_q     <= i_q - AW'(1);
					state_q <= S_LREQ;
				end
			end
		end
	end

	mjte_len_mem #(
		.DEPTH(MAX_ELEMENTS)
	) u_len_mem (
		.clk  (clk),
		.we   (accept && room),
		.waddr(count_q[AW-1:0]),
		.wdata(jump_length),
		.re   (state_q == S_LREQ),
		.raddr(i_q),
		.rdata(len_rd)
	);

	mjte_cost_mem #(
		.DEPTH(MAX_ELEMENTS)
	) u_cost_mem (
		.clk  (clk),
		.we   (cwe),
		.waddr(cwaddr),
		.wdata(cwdata),
		.re   (state_q == S_SCAN),
		.raddr(j_q),
		.rdata(cost_rd)
	);

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign min_jumps   = min_jumps_q;
	assign unreachable = unreachable_q;
	assign too_long    = too_long_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("element count beyond capacity");

	a_scan_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ((j_q > i_q) && (j_q <= end_q)))
		else $error("scan address outside reachable window");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !cwe)
		else $error("cost write overlaps window scan");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ((state_q == S_IDLE) && (count_q == '0) && !ovf_q))
		else $error("result shown while array state not cleared");

	a_scan_read_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !$past(cwe && (cwaddr == j_q)))
		else $error("cost read of an entry written in the previous cycle");
`endif
endmodule
